### src/pae_pkg.sv
package pae_pkg;

  // array geometry
  localparam int unsigned DEPTH  = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_DUP    = 3'd3,
    OP_REMOVE = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_COMPACT,
    S_PUT,
    S_READ,
    S_DONE
  } state_e;

  // one finished result
  typedef struct packed {
    status_e           status;
    logic [WORD_W-1:0] read_word;
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  removed_count;
  } res_t;

endpackage

### src/pae_ram.sv
module pae_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/pae_ctrl.sv
module pae_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [pae_pkg::OP_W-1:0]         operation_i,
  input  logic [pae_pkg::CNT_W-1:0]        position_i,
  input  logic [pae_pkg::WORD_W-1:0]       value_i,
  output logic                             busy_o,
  output logic                             res_valid_o,
  output pae_pkg::res_t                    res_o,
  output logic                             ram_we_o,
  output logic [pae_pkg::ADDR_W-1:0]       ram_waddr_o,
  output logic [pae_pkg::WORD_W-1:0]       ram_wdata_o,
  output logic                             ram_re_o,
  output logic [pae_pkg::ADDR_W-1:0]       ram_raddr_o,
  input  logic [pae_pkg::WORD_W-1:0]       ram_rdata_i
);

  localparam logic [pae_pkg::CNT_W-1:0] DepthC = pae_pkg::CNT_W'(pae_pkg::DEPTH);
  localparam logic [pae_pkg::CNT_W-1:0] OneC   = pae_pkg::CNT_W'(1);

  pae_pkg::state_e             state_q, state_d;
  pae_pkg::op_e                op_q, op_d;
  pae_pkg::status_e            status_q, status_d;
  logic [pae_pkg::CNT_W-1:0]   pos_q, pos_d;
  logic [pae_pkg::WORD_W-1:0]  val_q, val_d;
  logic [pae_pkg::WORD_W-1:0]  word_q, word_d;
  logic [pae_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [pae_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic [pae_pkg::CNT_W-1:0]   tgt_q, tgt_d;
  logic [pae_pkg::CNT_W-1:0]   at_q, at_d;
  logic [pae_pkg::CNT_W-1:0]   wr_q, wr_d;
  logic [pae_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic                        pend_q, pend_d;

  logic full;
  logic eq;
  logic match;
  logic issue;
  logic walk_end;
  logic ins_bad;
  logic del_bad;
  logic rd_bad;

  // shared word comparator and range checks
  assign full     = (cnt_q >= DepthC);
  assign eq       = (ram_rdata_i == val_q);
  assign match    = pend_q && eq;
  assign ins_bad  = (pos_q == '0) ||
                    ({1'b0, pos_q} > ({1'b0, cnt_q} + {1'b0, OneC}));
  assign del_bad  = (pos_q == '0) || (pos_q > cnt_q);
  assign rd_bad   = (pos_q >= cnt_q);

  // whether the walk issues a read this cycle
  always_comb begin
    issue = 1'b0;
    unique case (state_q)
      pae_pkg::S_SCAN:    issue = (idx_q < cnt_q) && !match;
      pae_pkg::S_SHUP:    issue = (idx_q > at_q);
      pae_pkg::S_SHDN,
      pae_pkg::S_COMPACT: issue = (idx_q < cnt_q);
      default:            issue = 1'b0;
    endcase
  end

  assign walk_end = !issue && !pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pae_pkg::S_IDLE: begin
        if (start_i) state_d = pae_pkg::S_DECIDE;
      end
      pae_pkg::S_DECIDE: begin
        unique case (op_q)
          pae_pkg::OP_APPEND: state_d = full ? pae_pkg::S_DONE : pae_pkg::S_PUT;
          pae_pkg::OP_INSERT: state_d = (ins_bad || full) ? pae_pkg::S_DONE : pae_pkg::S_SHUP;
          pae_pkg::OP_DELETE: state_d = del_bad ? pae_pkg::S_DONE : pae_pkg::S_SHDN;
          pae_pkg::OP_DUP:    state_d = pae_pkg::S_SCAN;
          pae_pkg::OP_REMOVE: state_d = pae_pkg::S_COMPACT;
          pae_pkg::OP_READ:   state_d = rd_bad ? pae_pkg::S_DONE : pae_pkg::S_READ;
          default:            state_d = pae_pkg::S_DONE;
        endcase
      end
      pae_pkg::S_SCAN: begin
        if (match) begin
          state_d = full ? pae_pkg::S_DONE : pae_pkg::S_SHUP;
        end else if (walk_end) begin
          state_d = pae_pkg::S_DONE;
        end
      end
      pae_pkg::S_SHUP: begin
        if (walk_end) state_d = pae_pkg::S_PUT;
      end
      pae_pkg::S_SHDN,
      pae_pkg::S_COMPACT: begin
        if (walk_end) state_d = pae_pkg::S_DONE;
      end
      pae_pkg::S_PUT,
      pae_pkg::S_READ: state_d = pae_pkg::S_DONE;
      pae_pkg::S_DONE: state_d = pae_pkg::S_IDLE;
      default:         state_d = pae_pkg::S_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    ram_re_o    = issue;
    ram_raddr_o = idx_q[pae_pkg::ADDR_W-1:0];
    ram_we_o    = 1'b0;
    ram_waddr_o = tgt_q[pae_pkg::ADDR_W-1:0];
    ram_wdata_o = ram_rdata_i;
    unique case (state_q)
      pae_pkg::S_DECIDE: begin
        ram_re_o    = (op_q == pae_pkg::OP_READ) && !rd_bad;
        ram_raddr_o = pos_q[pae_pkg::ADDR_W-1:0];
      end
      pae_pkg::S_SHUP: begin
        ram_raddr_o = idx_q[pae_pkg::ADDR_W-1:0] - pae_pkg::ADDR_W'(1);
        ram_we_o    = pend_q;
      end
      pae_pkg::S_SHDN: begin
        ram_we_o = pend_q;
      end
      pae_pkg::S_COMPACT: begin
        ram_we_o    = pend_q && !eq;
        ram_waddr_o = wr_q[pae_pkg::ADDR_W-1:0];
      end
      pae_pkg::S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = at_q[pae_pkg::ADDR_W-1:0];
        ram_wdata_o = val_q;
      end
      default: begin
      end
    endcase
  end

  assign busy_o      = (state_q != pae_pkg::S_IDLE);
  assign res_valid_o = (state_q == pae_pkg::S_DONE);
  assign res_o       = '{status:        status_q,
                         read_word:     word_q,
                         fill_count:    cnt_q,
                         removed_count: rem_q};

  // datapath next values
  always_comb begin
    op_d     = op_q;
    pos_d    = pos_q;
    val_d    = val_q;
    status_d = status_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    tgt_d    = tgt_q;
    at_d     = at_q;
    wr_d     = wr_q;
    rem_d    = rem_q;
    pend_d   = issue;
    unique case (state_q)
      pae_pkg::S_IDLE: begin
        if (start_i) begin
          op_d     = pae_pkg::op_e'(operation_i);
          pos_d    = position_i;
          val_d    = value_i;
          status_d = pae_pkg::ST_DONE;
          word_d   = '0;
          rem_d    = '0;
        end
      end
      pae_pkg::S_DECIDE: begin
        unique case (op_q)
          pae_pkg::OP_APPEND: begin
            if (full) status_d = pae_pkg::ST_FULL;
            at_d = cnt_q;
          end
          pae_pkg::OP_INSERT: begin
            if (ins_bad) status_d = pae_pkg::ST_RANGE;
            else if (full) status_d = pae_pkg::ST_FULL;
            at_d  = pos_q - OneC;
            idx_d = cnt_q;
          end
          pae_pkg::OP_DELETE: begin
            if (del_bad) status_d = pae_pkg::ST_RANGE;
            idx_d = pos_q;
          end
          pae_pkg::OP_DUP: begin
            idx_d = '0;
          end
          pae_pkg::OP_REMOVE: begin
            idx_d = '0;
            wr_d  = '0;
          end
          pae_pkg::OP_READ: begin
            if (rd_bad) status_d = pae_pkg::ST_RANGE;
          end
          default: begin
          end
        endcase
      end
      pae_pkg::S_SCAN: begin
        if (issue) begin
          idx_d = idx_q + OneC;
          tgt_d = idx_q;
        end
        // first match found: shift up from there
        if (match) begin
          at_d  = tgt_q;
          idx_d = cnt_q;
          if (full) status_d = pae_pkg::ST_FULL;
        end else if (walk_end) begin
          status_d = pae_pkg::ST_MISSING;
        end
      end
      pae_pkg::S_SHUP: begin
        if (issue) begin
          idx_d = idx_q - OneC;
          tgt_d = idx_q;
        end
      end
      pae_pkg::S_SHDN: begin
        if (issue) begin
          idx_d = idx_q + OneC;
          tgt_d = idx_q - OneC;
        end
        if (walk_end) cnt_d = cnt_q - OneC;
      end
      pae_pkg::S_COMPACT: begin
        if (issue) idx_d = idx_q + OneC;
        // keep non-matching entries in order
        if (pend_q) begin
          if (eq) rem_d = rem_q + OneC;
          else    wr_d  = wr_q + OneC;
        end
        if (walk_end) begin
          cnt_d = wr_q;
          if (rem_q == '0) status_d = pae_pkg::ST_MISSING;
        end
      end
      pae_pkg::S_PUT: begin
        cnt_d = cnt_q + OneC;
      end
      pae_pkg::S_READ: begin
        word_d = ram_rdata_i;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pae_pkg::S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    status_q <= status_d;
    word_q   <= word_d;
    idx_q    <= idx_d;
    tgt_q    <= tgt_d;
    at_q     <= at_d;
    wr_q     <= wr_d;
    rem_q    <= rem_d;
  end

endmodule

### src/positional_array_insert_delete_top.sv
// sequence: an accepted item goes to decide, then to put, read or a walk, or straight to done
// if rejected or spare; done_o is registered from done; searches, shifts and compaction walk the
// array one entry per cycle on the single ram read port
// throughput: one item at a time; busy_o drops as the result is registered
// reset: async active low; fill count cleared, array contents undefined until written
// the receiver cannot stall: each result shows for one cycle with done_o
module positional_array_insert_delete_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [pae_pkg::OP_W-1:0]           operation_i,
  input  logic [pae_pkg::CNT_W-1:0]          position_i,
  input  logic [pae_pkg::WORD_W-1:0]         value_i,
  output logic                               done_o,
  output logic [pae_pkg::STAT_W-1:0]         status_o,
  output logic [pae_pkg::WORD_W-1:0]         read_word_o,
  output logic [pae_pkg::CNT_W-1:0]          fill_count_o,
  output logic [pae_pkg::CNT_W-1:0]          removed_count_o
);

  logic                          ram_we;
  logic [pae_pkg::ADDR_W-1:0]    ram_waddr;
  logic [pae_pkg::WORD_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [pae_pkg::ADDR_W-1:0]    ram_raddr;
  logic [pae_pkg::WORD_W-1:0]    ram_rdata;
  logic                          res_valid;
  pae_pkg::res_t                 res;
  pae_pkg::res_t                 res_q;
  logic                          done_q;

  // element store
  pae_ram #(
    .WIDTH (pae_pkg::WORD_W),
    .DEPTH (pae_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer with shared compare unit
  pae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign done_o          = done_q;
  assign status_o        = res_q.status;
  assign read_word_o     = res_q.read_word;
  assign fill_count_o    = res_q.fill_count;
  assign removed_count_o = res_q.removed_count;

endmodule

### test/tb_positional_array_insert_delete_top.sv
`timescale 1ns / 100ps

module tb_positional_array_insert_delete_top;
  import pae_pkg::*;

  // spare operation codes, the block leaves the array alone
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned POOL_SIZE    = 6;
  localparam int unsigned PRINT_CAP    = 30;

  // random phase flavors
  localparam int unsigned MODE_GROW   = 0;
  localparam int unsigned MODE_SHRINK = 1;
  localparam int unsigned MODE_MIXED  = 2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  pos;
    logic [WORD_W-1:0] val;
    logic              typed;
    res_t              want;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [OP_W-1:0]    operation_i;
  logic [CNT_W-1:0]   position_i;
  logic [WORD_W-1:0]  value_i;
  logic               done_o;
  logic [STAT_W-1:0]  status_o;
  logic [WORD_W-1:0]  read_word_o;
  logic [CNT_W-1:0]   fill_count_o;
  logic [CNT_W-1:0]   removed_count_o;

  // shadow copy of the array contents and fill count
  logic [WORD_W-1:0]  shadow_words [DEPTH];
  int unsigned        shadow_fill;

  logic [WORD_W-1:0]  word_pool [POOL_SIZE];
  res_t               due_results [$];
  plan_row_t          directed_rows [$];
  res_t               oldest_due;
  int unsigned        mismatch_count = 0;
  int unsigned        result_seq = 0;
  int unsigned        idle_cycles = 0;

  positional_array_insert_delete_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_word_o     (read_word_o),
    .fill_count_o    (fill_count_o),
    .removed_count_o (removed_count_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t: result %0d: %s", $time, result_seq, msg);
    end
    mismatch_count++;
  endtask

  // open a slot at index at, later entries move up by one
  task automatic shadow_open_gap(input int unsigned at);
    int unsigned i;
    for (i = shadow_fill; i > at; i--) begin
      shadow_words[i] = shadow_words[i - 1];
    end
    shadow_fill++;
  endtask

  // apply one item to the shadow array and work out its result
  task automatic track_array_op(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
                                input logic [WORD_W-1:0] val, output res_t r);
    int unsigned i;
    int unsigned w;
    int unsigned hit;
    int unsigned removed;
    logic        full;
    r.status        = ST_DONE;
    r.read_word     = '0;
    removed         = 0;
    full            = (shadow_fill >= DEPTH);
    case (op)
      OP_APPEND: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_fill] = val;
          shadow_fill++;
        end
      end
      OP_INSERT: begin
        if (pos < 1 || pos > shadow_fill + 1) begin
          r.status = ST_RANGE;
        end else if (full) begin
          r.status = ST_FULL;
        end else begin
          shadow_open_gap(pos - 1);
          shadow_words[pos - 1] = val;
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = pos - 1; i + 1 < shadow_fill; i++) begin
            shadow_words[i] = shadow_words[i + 1];
          end
          shadow_fill--;
        end
      end
      OP_DUP: begin
        hit = shadow_fill;
        for (i = 0; i < shadow_fill && hit == shadow_fill; i++) begin
          if (shadow_words[i] == val) hit = i;
        end
        if (hit == shadow_fill) begin
          r.status = ST_MISSING;
        end else if (full) begin
          r.status = ST_FULL;
        end else begin
          shadow_open_gap(hit);
          shadow_words[hit] = val;
        end
      end
      OP_REMOVE: begin
        w = 0;
        for (i = 0; i < shadow_fill; i++) begin
          if (shadow_words[i] == val) begin
            removed++;
          end else begin
            shadow_words[w] = shadow_words[i];
            w++;
          end
        end
        shadow_fill = w;
        if (removed == 0) r.status = ST_MISSING;
      end
      OP_READ: begin
        if (pos >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          r.read_word = shadow_words[pos];
        end
      end
      default: begin
      end
    endcase
    r.fill_count    = CNT_W'(shadow_fill);
    r.removed_count = CNT_W'(removed);
  endtask

  // sender gap: mostly back to back, some short, a few long
  function automatic int unsigned draw_gap(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // operation mix depends on whether the phase fills or drains the array
  function automatic logic [OP_W-1:0] pick_op(input int unsigned mode);
    int unsigned roll;
    int unsigned c_app, c_ins, c_del, c_dup, c_rem, c_rd;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        c_app = 40; c_ins = 65; c_del = 70; c_dup = 82; c_rem = 85; c_rd = 97;
      end
      MODE_SHRINK: begin
        c_app = 10; c_ins = 15; c_del = 50; c_dup = 53; c_rem = 75; c_rd = 97;
      end
      default: begin
        c_app = 18; c_ins = 36; c_del = 52; c_dup = 66; c_rem = 78; c_rd = 97;
      end
    endcase
    if (roll < c_app) return OP_APPEND;
    if (roll < c_ins) return OP_INSERT;
    if (roll < c_del) return OP_DELETE;
    if (roll < c_dup) return OP_DUP;
    if (roll < c_rem) return OP_REMOVE;
    if (roll < c_rd)  return OP_READ;
    return ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
  endfunction

  // positions mostly legal for the current fill, sometimes anything in range
  function automatic logic [CNT_W-1:0] pick_position(input logic [OP_W-1:0] op);
    int unsigned top;
    top = (shadow_fill + 1 > DEPTH) ? DEPTH : shadow_fill + 1;
    if ($urandom_range(0, 9) == 0) return CNT_W'($urandom_range(0, DEPTH));
    case (op)
      OP_INSERT: return CNT_W'($urandom_range(1, top));
      OP_DELETE: if (shadow_fill > 0) return CNT_W'($urandom_range(1, shadow_fill));
      OP_READ:   if (shadow_fill > 0) return CNT_W'($urandom_range(0, shadow_fill - 1));
      default: begin
      end
    endcase
    return CNT_W'($urandom_range(0, DEPTH));
  endfunction

  // searches mostly hit a stored word, stores mostly draw from a small pool
  function automatic logic [WORD_W-1:0] pick_value(input logic [OP_W-1:0] op);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if ((op == OP_DUP || op == OP_REMOVE) && shadow_fill > 0 && roll < 7) begin
      return shadow_words[$urandom_range(0, shadow_fill - 1)];
    end
    if (roll < 8) return word_pool[$urandom_range(0, POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
                         input logic [WORD_W-1:0] val);
    plan_row_t row;
    row       = '0;
    row.op    = op;
    row.pos   = pos;
    row.val   = val;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
                           input logic [WORD_W-1:0] val, input status_e st,
                           input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] fill,
                           input logic [CNT_W-1:0] removed);
    plan_row_t row;
    row                    = '0;
    row.op                 = op;
    row.pos                = pos;
    row.val                = val;
    row.typed              = 1'b1;
    row.want.status        = st;
    row.want.read_word     = word;
    row.want.fill_count    = fill;
    row.want.removed_count = removed;
    directed_rows.push_back(row);
  endtask

  // present one item, hold it until the block takes it, then log its result
  task automatic issue_item(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
                            input logic [WORD_W-1:0] val, input logic typed,
                            input res_t want, input int unsigned gap);
    res_t predicted;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    value_i     <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    track_array_op(op, pos, val, predicted);
    due_results.push_back(typed ? want : predicted);
  endtask

  // stimulus
  initial begin
    int unsigned issued;
    int unsigned k;
    int unsigned phase_len;
    int unsigned mode_roll;
    int unsigned mode;
    int unsigned p;
    bit          quiet;
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  pos;
    logic [WORD_W-1:0] val;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    operation_i <= '0;
    position_i  <= '0;
    value_i     <= '0;
    shadow_fill = 0;
    for (k = 0; k < DEPTH; k++) shadow_words[k] = '0;

    // empty array: every lookup and delete is rejected
    add_typed(OP_READ,   6'd0,  '0, ST_RANGE,   '0, 6'd0, 6'd0);
    add_typed(OP_DELETE, 6'd1,  '0, ST_RANGE,   '0, 6'd0, 6'd0);
    add_typed(OP_REMOVE, 6'd0,  '0, ST_MISSING, '0, 6'd0, 6'd0);
    add_typed(OP_DUP,    6'd0,  '0, ST_MISSING, '0, 6'd0, 6'd0);
    // position zero and one past fill+1 are out of range
    add_typed(OP_INSERT, 6'd0,  '1, ST_RANGE,   '0, 6'd0, 6'd0);
    add_typed(OP_INSERT, 6'd2,  '1, ST_RANGE,   '0, 6'd0, 6'd0);
    // load four words with extreme patterns
    add_typed(OP_INSERT, 6'd1,  '1, ST_DONE,    '0, 6'd1, 6'd0);
    add_typed(OP_APPEND, 6'd63, '0, ST_DONE,    '0, 6'd2, 6'd0);
    add_typed(OP_APPEND, 6'd0,  {32{2'b01}}, ST_DONE, '0, 6'd3, 6'd0);
    add_typed(OP_APPEND, 6'd0,  {32{2'b10}}, ST_DONE, '0, 6'd4, 6'd0);
    add_typed(OP_READ,   6'd0,  '0, ST_DONE,    '1, 6'd4, 6'd0);
    add_typed(OP_READ,   6'd3,  '0, ST_DONE,    {32{2'b10}}, 6'd4, 6'd0);
    add_typed(OP_READ,   6'd4,  '0, ST_RANGE,   '0, 6'd4, 6'd0);
    add_typed(OP_READ,   6'd32, '0, ST_RANGE,   '0, 6'd4, 6'd0);
    // insert at fill+1, duplicate twice, then remove every copy of that word
    add_row(OP_INSERT, 6'd5,  {32{2'b01}});
    add_row(OP_DUP,    6'd0,  {32{2'b01}});
    add_row(OP_DUP,    6'd0,  {32{2'b01}});
    add_row(OP_REMOVE, 6'd0,  {32{2'b01}});
    add_row(OP_DELETE, 6'd0,  '0);
    add_row(OP_DELETE, 6'd3,  '0);
    add_row(OP_DELETE, 6'd1,  '0);
    add_row(OP_SPARE_LO, 6'd1, '1);
    add_row(OP_SPARE_HI, 6'd32, '1);
    add_row(OP_INSERT, 6'd32, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      issue_item(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                 directed_rows[i].typed, directed_rows[i].want, draw_gap(1'b0));
    end

    // random phases, each with its own operation mix and word pool
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 80);
      mode_roll = $urandom_range(0, 9);
      mode      = (mode_roll < 4) ? MODE_GROW : (mode_roll < 7) ? MODE_SHRINK : MODE_MIXED;
      quiet     = ($urandom_range(0, 3) == 0);
      for (p = 0; p < POOL_SIZE; p++) begin
        case ($urandom_range(0, 7))
          0:       word_pool[p] = '0;
          1:       word_pool[p] = '1;
          default: word_pool[p] = {$urandom, $urandom};
        endcase
      end
      for (k = 0; k < phase_len && issued < RANDOM_ITEMS; k++) begin
        op  = pick_op(mode);
        pos = pick_position(op);
        val = pick_value(op);
        issue_item(op, pos, val, 1'b0, '0, draw_gap(quiet));
        if (op != OP_SPARE_LO && op != OP_SPARE_HI) issued++;
      end
    end
    start_i <= 1'b0;

    // drain, then watch for stray strobes
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch("result strobe with no item outstanding");
      end else begin
        oldest_due = due_results.pop_front();
        if (status_o !== oldest_due.status) begin
          report_mismatch($sformatf("status got %0d want %0d", status_o, oldest_due.status));
        end
        if (read_word_o !== oldest_due.read_word) begin
          report_mismatch($sformatf("read_word got %h want %h", read_word_o,
                                    oldest_due.read_word));
        end
        if (fill_count_o !== oldest_due.fill_count) begin
          report_mismatch($sformatf("fill_count got %0d want %0d", fill_count_o,
                                    oldest_due.fill_count));
        end
        if (removed_count_o !== oldest_due.removed_count) begin
          report_mismatch($sformatf("removed_count got %0d want %0d", removed_count_o,
                                    oldest_due.removed_count));
        end
      end
      result_seq++;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item accepted or returned for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### positional_array_insert_delete_top.f
src/pae_pkg.sv
src/pae_ram.sv
src/pae_ctrl.sv
src/positional_array_insert_delete_top.sv
test/tb_positional_array_insert_delete_top.sv
